[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion forms for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define ASSERT_ALWAYS(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// property checked at every edge, reset included
`define ASSERT_RESET(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

[hdl/fms_pkg.sv]
// ----------------------------------------------------------------------------
// fms_pkg
// codes, widths and reset values of the flight mode supervisor
// ----------------------------------------------------------------------------
package fms_pkg;

    localparam int TIMER_WIDTH_DEF = 32;
    localparam int DT_W            = 16;
    localparam int TIMEOUT_W       = 32;
    localparam int ALT_W           = 24;
    localparam int TOL_W           = 23;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_IDX_W       = 2;
    localparam int S_DATA_W        = 80;
    localparam int M_DATA_W        = 16;

    // mission state codes
    localparam logic [3:0] ST_ON       = 4'd0;
    localparam logic [3:0] ST_MEM      = 4'd1;
    localparam logic [3:0] ST_SENS     = 4'd2;
    localparam logic [3:0] ST_CAL      = 4'd3;
    localparam logic [3:0] ST_EST      = 4'd4;
    localparam logic [3:0] ST_DISARMED = 4'd5;
    localparam logic [3:0] ST_MOTOR    = 4'd6;
    localparam logic [3:0] ST_ARMED    = 4'd7;
    localparam logic [3:0] ST_FLIGHT   = 4'd8;

    // failsafe codes
    localparam logic [2:0] FS_NONE   = 3'd0;
    localparam logic [2:0] FS_SENSOR = 3'd1;
    localparam logic [2:0] FS_EST    = 3'd2;
    localparam logic [2:0] FS_ALT    = 3'd3;
    localparam logic [2:0] FS_RC     = 3'd4;

    // check result codes
    localparam logic [1:0] CK_PENDING = 2'd0;
    localparam logic [1:0] CK_PASSED  = 2'd1;
    localparam logic [1:0] CK_FAILED  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALT_TOL     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALT_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RC_REQUIRED = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RC_TIMEOUT  = 2'd3;

    // register reset values
    localparam logic [TOL_W-1:0]     ALT_TOL_RST     = 23'd1000;
    localparam logic [TIMEOUT_W-1:0] ALT_TIMEOUT_RST = 32'd2000000;
    localparam logic                 RC_REQUIRED_RST = 1'b1;
    localparam logic [TIMEOUT_W-1:0] RC_TIMEOUT_RST  = 32'd1000000;

    // control of one elapsed-time timer
    typedef struct packed {
        logic step;
        logic run;
    } fms_tmr_ctl_t;

endpackage

[hdl/fms_timer.sv]
// ----------------------------------------------------------------------------
// fms_timer
// saturating elapsed-time timer with a strict timeout compare
// ----------------------------------------------------------------------------
module fms_timer
    import fms_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fms_tmr_ctl_t         ctl,
    input  logic [DT_W-1:0]      dt,
    input  logic [TIMEOUT_W-1:0] timeout,
    output logic                 trip
);

    localparam int CMP_W = (TIMER_WIDTH > TIMEOUT_W) ? TIMER_WIDTH : TIMEOUT_W;

    logic [TIMER_WIDTH-1:0] time_reg;
    logic [TIMER_WIDTH-1:0] time_next;
    logic [TIMER_WIDTH:0]   sum;

    assign sum = {1'b0, time_reg} + {{(TIMER_WIDTH + 1 - DT_W){1'b0}}, dt};

    always_comb begin
        if (!ctl.run) begin
            time_next = '0;
        end else if (sum >= {1'b0, {TIMER_WIDTH{1'b1}}}) begin
            time_next = {TIMER_WIDTH{1'b1}};
        end else begin
            time_next = sum[TIMER_WIDTH-1:0];
        end
    end

    assign trip = ctl.run && (CMP_W'(time_next) > CMP_W'(timeout));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg <= '0;
        end else if (ctl.step) begin
            time_reg <= time_next;
        end
    end

endmodule

[hdl/flight_mode_supervisor_core.sv]
// the result item of an accepted input item is registered in the output register
// throughput: one item per cycle unless a held result stalls input; the mission state,
// failsafe and timers update in the same cycle the item is accepted
// a result waiting in the output register does not stall input while m_tready is high
// reset: synchronous active-low aresetn returns the mission to on, clears the
// timers and edge copies and reloads the register defaults
// ----------------------------------------------------------------------------
// flight_mode_supervisor_core
// mission sequencer and failsafe supervisor, one control tick per item
// ----------------------------------------------------------------------------
module flight_mode_supervisor_core
    import fms_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // landed, arm_switch, takeoff_trigger, sensor_failed, estimator_degraded,
    // estimator_converged, rc_valid, check_results[7:0], altitude_mm[23:0],
    // altitude_target_mm[23:0], tick_us[15:0], zero pad
    input  logic [S_DATA_W-1:0]   s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // mission_state[3:0], failsafe_code[2:0], motors_enabled, reset_estimator,
    // reset_controller, start_motor_check, zero pad
    output logic [M_DATA_W-1:0]   m_tdata
);

    logic [TOL_W-1:0]     alt_tol_reg;
    logic [TIMEOUT_W-1:0] alt_timeout_reg;
    logic                 rc_required_reg;
    logic [TIMEOUT_W-1:0] rc_timeout_reg;

    logic [3:0] mode_reg, mode_next;
    logic [2:0] failsafe_next;
    logic       arm_prev_reg, trigger_prev_reg, landed_prev_reg;
    logic       m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic              landed, arm, trig, sens_fail, est_deg, est_conv, rc_ok;
    logic [7:0]        checks;
    logic signed [ALT_W-1:0] alt, tgt;
    logic [DT_W-1:0]   dt;

    logic accept;
    logic touchdown, arm_edge, trig_edge, in_air, ground_live, live;
    logic sens_trip, est_trip, alt_trip, rc_trip;
    logic rst_est, rst_ctl, start_mc, motors;
    logic signed [ALT_W:0] err;
    logic [ALT_W:0]        err_abs;
    fms_tmr_ctl_t alt_ctl, rc_ctl;

    assign landed    = s_tdata[0];
    assign arm       = s_tdata[1];
    assign trig      = s_tdata[2];
    assign sens_fail = s_tdata[3];
    assign est_deg   = s_tdata[4];
    assign est_conv  = s_tdata[5];
    assign rc_ok     = s_tdata[6];
    assign checks    = s_tdata[14:7];
    assign alt       = s_tdata[38:15];
    assign tgt       = s_tdata[62:39];
    assign dt        = s_tdata[78:63];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign touchdown   = landed && !landed_prev_reg;
    assign arm_edge    = arm && !arm_prev_reg;
    assign trig_edge   = trig && !trigger_prev_reg;
    assign in_air      = (mode_reg == ST_FLIGHT);
    assign ground_live = (mode_reg == ST_DISARMED) || (mode_reg == ST_MOTOR) ||
                         (mode_reg == ST_ARMED);
    assign live        = ground_live || in_air;
    assign sens_trip   = live && sens_fail;
    assign est_trip    = live && est_deg;

    assign err     = {alt[ALT_W-1], alt} - {tgt[ALT_W-1], tgt};
    assign err_abs = err[ALT_W] ? (ALT_W+1)'(-err) : err;

    assign alt_ctl.step = accept;
    assign alt_ctl.run  = in_air && (err_abs > {2'b00, alt_tol_reg});
    assign rc_ctl.step  = accept;
    assign rc_ctl.run   = rc_required_reg && ((mode_reg == ST_ARMED) || in_air) && !rc_ok;

    fms_timer #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_alt_timer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (alt_ctl),
        .dt      (dt),
        .timeout (alt_timeout_reg),
        .trip    (alt_trip)
    );

    fms_timer #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_rc_timer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (rc_ctl),
        .dt      (dt),
        .timeout (rc_timeout_reg),
        .trip    (rc_trip)
    );

    always_comb begin
        if (sens_trip) begin
            failsafe_next = FS_SENSOR;
        end else if (est_trip) begin
            failsafe_next = FS_EST;
        end else if (alt_trip) begin
            failsafe_next = FS_ALT;
        end else if (rc_trip) begin
            failsafe_next = FS_RC;
        end else begin
            failsafe_next = FS_NONE;
        end
    end

    assign rst_est = est_trip && ground_live;

    always_comb begin
        mode_next = mode_reg;
        rst_ctl   = 1'b0;
        start_mc  = 1'b0;
        if (failsafe_next == FS_NONE) begin
            case (mode_reg)
                ST_ON: begin
                    mode_next = ST_MEM;
                end
                ST_MEM: begin
                    if (checks[1:0] == CK_PASSED) mode_next = ST_SENS;
                end
                ST_SENS: begin
                    if (checks[3:2] == CK_PASSED) mode_next = ST_CAL;
                end
                ST_CAL: begin
                    if (checks[5:4] == CK_PASSED) mode_next = ST_EST;
                end
                ST_EST: begin
                    if (est_conv) mode_next = ST_DISARMED;
                end
                ST_DISARMED: begin
                    if (arm_edge) begin
                        rst_ctl   = 1'b1;
                        start_mc  = 1'b1;
                        mode_next = ST_MOTOR;
                    end
                end
                ST_MOTOR: begin
                    if (checks[7:6] == CK_PASSED) begin
                        mode_next = ST_ARMED;
                    end else if (checks[7:6] == CK_FAILED) begin
                        mode_next = ST_DISARMED;
                    end
                end
                ST_ARMED: begin
                    if (!arm) begin
                        mode_next = ST_DISARMED;
                    end else if (trig_edge) begin
                        mode_next = ST_FLIGHT;
                    end
                end
                ST_FLIGHT: begin
                    if (!arm && landed) begin
                        mode_next = ST_DISARMED;
                    end else if (touchdown) begin
                        rst_ctl   = 1'b1;
                        mode_next = ST_ARMED;
                    end
                end
                default: begin
                    mode_next = mode_reg;
                end
            endcase
        end else if ((mode_reg == ST_MOTOR) || (mode_reg == ST_ARMED) ||
                     (in_air && touchdown)) begin
            mode_next = ST_DISARMED;
        end
    end

    assign motors = ((mode_next == ST_MOTOR) || (mode_next == ST_ARMED) ||
                     (mode_next == ST_FLIGHT)) && (failsafe_next != FS_SENSOR);

    assign m_tdata_next = {5'b0, start_mc, rst_ctl, rst_est, motors,
                           failsafe_next, mode_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alt_tol_reg     <= ALT_TOL_RST;
            alt_timeout_reg <= ALT_TIMEOUT_RST;
            rc_required_reg <= RC_REQUIRED_RST;
            rc_timeout_reg  <= RC_TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ALT_TOL:     alt_tol_reg     <= cfg_wdata[TOL_W-1:0];
                CFG_ALT_TIMEOUT: alt_timeout_reg <= cfg_wdata[TIMEOUT_W-1:0];
                CFG_RC_REQUIRED: rc_required_reg <= cfg_wdata[0];
                CFG_RC_TIMEOUT:  rc_timeout_reg  <= cfg_wdata[TIMEOUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= ST_ON;
            arm_prev_reg     <= 1'b0;
            trigger_prev_reg <= 1'b0;
            landed_prev_reg  <= 1'b0;
        end else if (accept) begin
            mode_reg         <= mode_next;
            arm_prev_reg     <= arm;
            trigger_prev_reg <= trig;
            landed_prev_reg  <= landed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[hdl/fms_checker.sv]
// ----------------------------------------------------------------------------
// fms_checker
// port-level checks of the flight mode supervisor, bound to flight_mode_supervisor_core
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fms_checker
    import fms_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_DATA_W-1:0]   m_tdata
);

    logic [3:0] st_code;
    logic [2:0] fs_code;
    logic       motors;
    logic       rst_ctl;
    logic       start_mc;
    logic       motor_mode;
    logic       stall;

    assign st_code    = m_tdata[3:0];
    assign fs_code    = m_tdata[6:4];
    assign motors     = m_tdata[7];
    assign rst_ctl    = m_tdata[9];
    assign start_mc   = m_tdata[10];
    assign motor_mode = (st_code == ST_MOTOR) || (st_code == ST_ARMED) ||
                        (st_code == ST_FLIGHT);
    assign stall      = m_tvalid && !m_tready;

    `ASSERT_RESET(a_reset_empty, aclk, !aresetn |=> !m_tvalid)
    `ASSERT_ALWAYS(a_stall_hold, aclk, aresetn, stall |=> m_tvalid && $stable(m_tdata))
    `ASSERT_ALWAYS(a_motors_live, aclk, aresetn, m_tvalid && motors |-> motor_mode)
    `ASSERT_ALWAYS(a_sensor_loss_off, aclk, aresetn, m_tvalid && (fs_code == FS_SENSOR) |-> !motors)
    `ASSERT_ALWAYS(a_arm_pulses, aclk, aresetn, m_tvalid && start_mc |-> rst_ctl && (st_code == ST_MOTOR))

endmodule

bind flight_mode_supervisor_core fms_checker u_fms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for flight_mode_supervisor_core. Control ticks go in on the
// s_ stream and one status item per tick comes back on the m_ stream. A
// scoreboard keeps its own copy of the mission sequencer, the failsafe
// priority and the saturating timers, predicts each status item and compares
// every field. A short directed walk through boot, arming, flight and
// touchdown is followed by random ticks under several register settings,
// with random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb_top;
    import fms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIMER_W = TIMER_WIDTH_DEF;
    localparam logic [1:0] CK_UNDEFINED = 2'd3;
    localparam logic [7:0] ALL_PASSED = {CK_PASSED, CK_PASSED, CK_PASSED, CK_PASSED};

    // fields from the lowest bit up: landed .. tick_us, zero pad
    typedef struct packed {
        logic              pad;
        logic [15:0]       tick_us;
        logic signed [23:0] altitude_target_mm;
        logic signed [23:0] altitude_mm;
        logic [7:0]        check_results;
        logic              rc_valid;
        logic              estimator_converged;
        logic              estimator_degraded;
        logic              sensor_failed;
        logic              takeoff_trigger;
        logic              arm_switch;
        logic              landed;
    } tick_t;

    typedef struct packed {
        logic [4:0] pad;
        logic       start_motor_check;
        logic       reset_controller;
        logic       reset_estimator;
        logic       motors_enabled;
        logic [2:0] failsafe_code;
        logic [3:0] mission_state;
    } status_t;

    class fms_scoreboard;
        logic [TOL_W-1:0]     alt_tol;
        logic [TIMEOUT_W-1:0] alt_timeout;
        logic                 rc_required;
        logic [TIMEOUT_W-1:0] rc_timeout;
        logic [3:0]           mode;
        logic [2:0]           failsafe;
        logic                 arm_q;
        logic                 trig_q;
        logic                 landed_q;
        logic [TIMER_W-1:0]   alt_err_time;
        logic [TIMER_W-1:0]   rc_lost_time;
        status_t              expected_status[$];
        int                   errors;
        int                   mismatches;

        function new();
            alt_tol = ALT_TOL_RST;
            alt_timeout = ALT_TIMEOUT_RST;
            rc_required = RC_REQUIRED_RST;
            rc_timeout = RC_TIMEOUT_RST;
            mode = ST_ON;
            failsafe = FS_NONE;
            arm_q = 1'b0;
            trig_q = 1'b0;
            landed_q = 1'b0;
            alt_err_time = '0;
            rc_lost_time = '0;
            errors = 0;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_ALT_TOL:     alt_tol = val[TOL_W-1:0];
                CFG_ALT_TIMEOUT: alt_timeout = val[TIMEOUT_W-1:0];
                CFG_RC_REQUIRED: rc_required = val[0];
                CFG_RC_TIMEOUT:  rc_timeout = val[TIMEOUT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [TIMER_W-1:0] add_saturating(logic [TIMER_W-1:0] t, logic [15:0] dt);
            logic [TIMER_W:0] sum;
            sum = {1'b0, t} + {{(TIMER_W + 1 - 16){1'b0}}, dt};
            if (sum[TIMER_W])
                return {TIMER_W{1'b1}};
            return sum[TIMER_W-1:0];
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        function void note_input(tick_t t);
            status_t r;
            logic    touchdown, arm_edge, trig_edge, in_air, ground_live, live;
            logic    est_trip, alt_trip, rc_trip;
            longint  alt_err;
            logic [1:0] mc;
            r = '0;
            touchdown = t.landed && !landed_q;
            arm_edge = t.arm_switch && !arm_q;
            trig_edge = t.takeoff_trigger && !trig_q;
            in_air = (mode == ST_FLIGHT);
            ground_live = (mode == ST_DISARMED) || (mode == ST_MOTOR) || (mode == ST_ARMED);
            live = ground_live || in_air;
            est_trip = live && t.estimator_degraded;

            alt_err = longint'(t.altitude_mm) - longint'(t.altitude_target_mm);
            if (alt_err < 0)
                alt_err = -alt_err;
            alt_trip = 1'b0;
            if (!in_air || alt_err <= longint'(alt_tol)) begin
                alt_err_time = '0;
            end else begin
                alt_err_time = add_saturating(alt_err_time, t.tick_us);
                alt_trip = alt_err_time > alt_timeout;
            end

            rc_trip = 1'b0;
            if (!rc_required || !(mode == ST_ARMED || in_air) || t.rc_valid) begin
                rc_lost_time = '0;
            end else begin
                rc_lost_time = add_saturating(rc_lost_time, t.tick_us);
                rc_trip = rc_lost_time > rc_timeout;
            end

            if (live && t.sensor_failed)
                failsafe = FS_SENSOR;
            else if (est_trip)
                failsafe = FS_EST;
            else if (alt_trip)
                failsafe = FS_ALT;
            else if (rc_trip)
                failsafe = FS_RC;
            else
                failsafe = FS_NONE;

            r.reset_estimator = est_trip && ground_live;

            if (failsafe == FS_NONE) begin
                case (mode)
                    ST_ON: mode = ST_MEM;
                    ST_MEM: if (t.check_results[1:0] == CK_PASSED) mode = ST_SENS;
                    ST_SENS: if (t.check_results[3:2] == CK_PASSED) mode = ST_CAL;
                    ST_CAL: if (t.check_results[5:4] == CK_PASSED) mode = ST_EST;
                    ST_EST: if (t.estimator_converged) mode = ST_DISARMED;
                    ST_DISARMED: begin
                        if (arm_edge) begin
                            r.reset_controller = 1'b1;
                            r.start_motor_check = 1'b1;
                            mode = ST_MOTOR;
                        end
                    end
                    ST_MOTOR: begin
                        mc = t.check_results[7:6];
                        if (mc == CK_PASSED)
                            mode = ST_ARMED;
                        else if (mc == CK_FAILED)
                            mode = ST_DISARMED;
                    end
                    ST_ARMED: begin
                        if (!t.arm_switch)
                            mode = ST_DISARMED;
                        else if (trig_edge)
                            mode = ST_FLIGHT;
                    end
                    ST_FLIGHT: begin
                        if (!t.arm_switch && t.landed) begin
                            mode = ST_DISARMED;
                        end else if (touchdown) begin
                            r.reset_controller = 1'b1;
                            mode = ST_ARMED;
                        end
                    end
                    default: ;
                endcase
            end else if (mode == ST_MOTOR || mode == ST_ARMED || (in_air && touchdown)) begin
                mode = ST_DISARMED;
            end

            arm_q = t.arm_switch;
            trig_q = t.takeoff_trigger;
            landed_q = t.landed;

            r.mission_state = mode;
            r.failsafe_code = failsafe;
            r.motors_enabled = (mode == ST_MOTOR || mode == ST_ARMED || mode == ST_FLIGHT)
                               && (failsafe != FS_SENSOR);
            expected_status.push_back(r);
        endfunction

        function void check_result(status_t got);
            status_t want;
            if (expected_status.size() == 0) begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: status item with none expected: %h", got);
                return;
            end
            want = expected_status.pop_front();
            if (got.mission_state !== want.mission_state ||
                got.failsafe_code !== want.failsafe_code ||
                got.motors_enabled !== want.motors_enabled ||
                got.reset_estimator !== want.reset_estimator ||
                got.reset_controller !== want.reset_controller ||
                got.start_motor_check !== want.start_motor_check) begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR exp/act st %0d/%0d fs %0d/%0d mot %b/%b pulses %b%b%b/%b%b%b",
                             want.mission_state, got.mission_state,
                             want.failsafe_code, got.failsafe_code,
                             want.motors_enabled, got.motors_enabled,
                             want.reset_estimator, want.reset_controller,
                             want.start_motor_check,
                             got.reset_estimator, got.reset_controller,
                             got.start_motor_check);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;

    fms_scoreboard sb;

    int   send_calm;
    int   sink_calm;
    int   sink_hold;
    logic lvl_landed;
    logic lvl_arm;
    logic lvl_trig;

    flight_mode_supervisor_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function int pick_gap();
        int r;
        if (send_calm > 0) begin
            send_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            send_calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 50);
    endfunction

    function logic sink_ready();
        int r;
        if (sink_calm > 0) begin
            sink_calm--;
            return 1'b1;
        end
        if (sink_hold > 0) begin
            sink_hold--;
            return 1'b0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            sink_calm = $urandom_range(20, 80);
            return 1'b1;
        end
        if (r < 4) begin
            sink_hold = $urandom_range(10, 40);
            return 1'b0;
        end
        return r >= 25;
    endfunction

    function tick_t random_tick();
        tick_t t;
        int    sel;
        t = '0;
        if ($urandom_range(0, 4) == 0) lvl_landed = !lvl_landed;
        if ($urandom_range(0, 5) == 0) lvl_arm = !lvl_arm;
        if ($urandom_range(0, 2) == 0) lvl_trig = !lvl_trig;
        t.landed = lvl_landed;
        t.arm_switch = lvl_arm;
        t.takeoff_trigger = lvl_trig;
        t.sensor_failed = ($urandom_range(0, 24) == 0);
        t.estimator_degraded = ($urandom_range(0, 24) == 0);
        t.estimator_converged = ($urandom_range(0, 4) != 0);
        t.rc_valid = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < 4; i++)
            t.check_results[2*i +: 2] = ($urandom_range(0, 3) == 0) ?
                                        2'($urandom_range(0, 3)) : CK_PASSED;
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            t.altitude_target_mm = 24'(int'($urandom_range(0, 40000)) - 20000);
            t.altitude_mm = 24'(t.altitude_target_mm +
                                (int'($urandom_range(0, 6000)) - 3000));
        end else if (sel < 9) begin
            t.altitude_target_mm = 24'($urandom);
            t.altitude_mm = 24'($urandom);
        end else begin
            t.altitude_target_mm = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            t.altitude_mm = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
        end
        sel = $urandom_range(0, 9);
        if (sel < 6)
            t.tick_us = 16'($urandom_range(0, 2000));
        else if (sel < 9)
            t.tick_us = 16'($urandom_range(0, 65535));
        else
            t.tick_us = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        return t;
    endfunction

    task automatic send_tick(input tick_t t);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= t;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(t);
        @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_register(idx, val);
        @(negedge aclk);
    endtask

    task automatic configure(input int phase);
        case (phase)
            1: begin
                write_register(CFG_ALT_TOL, 32'd0);
                write_register(CFG_ALT_TIMEOUT, 32'd0);
                write_register(CFG_RC_REQUIRED, 32'd1);
                write_register(CFG_RC_TIMEOUT, 32'd0);
            end
            2: begin
                write_register(CFG_ALT_TOL, 32'h007F_FFFF);
                write_register(CFG_ALT_TIMEOUT, 32'hFFFF_FFFF);
                write_register(CFG_RC_REQUIRED, 32'd0);
                write_register(CFG_RC_TIMEOUT, 32'hFFFF_FFFF);
            end
            3: begin
                write_register(CFG_ALT_TOL, $urandom_range(0, 4000));
                write_register(CFG_ALT_TIMEOUT, $urandom_range(0, 20000));
                write_register(CFG_RC_REQUIRED, 32'd1);
                write_register(CFG_RC_TIMEOUT, $urandom_range(0, 20000));
            end
            default: begin
                write_register(CFG_ALT_TOL, $urandom);
                write_register(CFG_ALT_TIMEOUT, $urandom_range(0, 200000));
                write_register(CFG_RC_REQUIRED, $urandom);
                write_register(CFG_RC_TIMEOUT, $urandom_range(0, 200000));
            end
        endcase
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    initial begin
        m_tready = 1'b0;
        sink_calm = 0;
        sink_hold = 0;
        forever begin
            @(negedge aclk);
            m_tready <= sink_ready();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    initial begin
        tick_t t;
        sb = new();
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_ALT_TOL;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        send_calm = 0;
        lvl_landed = 1'b1;
        lvl_arm = 1'b0;
        lvl_trig = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // boot sequence with held and undefined check codes
        t = '0;
        t.landed = 1'b1;
        t.estimator_converged = 1'b1;
        t.rc_valid = 1'b1;
        t.tick_us = 16'd1000;
        send_tick(t);
        t.check_results = {CK_PENDING, CK_PENDING, CK_PENDING, CK_FAILED};
        send_tick(t);
        t.check_results = {CK_PENDING, CK_PENDING, CK_PENDING, CK_UNDEFINED};
        send_tick(t);
        t.check_results = {CK_PENDING, CK_PENDING, CK_PENDING, CK_PASSED};
        send_tick(t);
        t.check_results = {CK_PENDING, CK_PENDING, CK_FAILED, CK_PASSED};
        t.sensor_failed = 1'b1;
        send_tick(t);
        t.sensor_failed = 1'b0;
        t.check_results = ALL_PASSED;
        send_tick(t);
        send_tick(t);
        t.estimator_converged = 1'b0;
        t.estimator_degraded = 1'b1;
        send_tick(t);
        t.estimator_converged = 1'b1;
        t.estimator_degraded = 1'b0;
        send_tick(t);

        // arm edge eaten by a degraded estimator, then a real arm
        t.arm_switch = 1'b1;
        t.estimator_degraded = 1'b1;
        send_tick(t);
        t.estimator_degraded = 1'b0;
        send_tick(t);
        t.arm_switch = 1'b0;
        send_tick(t);
        t.arm_switch = 1'b1;
        t.check_results = {CK_PENDING, CK_PASSED, CK_PASSED, CK_PASSED};
        send_tick(t);
        t.check_results = {CK_UNDEFINED, CK_PASSED, CK_PASSED, CK_PASSED};
        send_tick(t);
        t.check_results = {CK_FAILED, CK_PASSED, CK_PASSED, CK_PASSED};
        send_tick(t);
        t.arm_switch = 1'b0;
        send_tick(t);
        t.arm_switch = 1'b1;
        send_tick(t);
        t.check_results = ALL_PASSED;
        send_tick(t);

        // takeoff with the radio down, altitude extremes in the air, touchdown
        t.takeoff_trigger = 1'b1;
        t.landed = 1'b0;
        t.rc_valid = 1'b0;
        send_tick(t);
        t.rc_valid = 1'b1;
        t.altitude_mm = 24'h7FFFFF;
        t.altitude_target_mm = 24'h800000;
        t.tick_us = 16'hFFFF;
        send_tick(t);
        t.arm_switch = 1'b0;
        send_tick(t);
        t.arm_switch = 1'b1;
        t.landed = 1'b1;
        t.altitude_mm = '0;
        t.altitude_target_mm = '0;
        t.tick_us = '0;
        send_tick(t);
        t.sensor_failed = 1'b1;
        send_tick(t);
        drain();

        lvl_arm = 1'b1;
        for (int phase = 0; phase < 5; phase++) begin
            if (phase > 0)
                configure(phase);
            repeat (210) send_tick(random_tick());
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
